### hw/rtl/pwlti_pkg.sv
// Shared types and constants for the piecewise linear table interpolator.
// No dependencies; every other file of the block but pwlti_channels refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package pwlti_pkg;

  // Input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result range codes
  localparam logic [1:0] RC_INTERIOR = 2'd0;
  localparam logic [1:0] RC_BELOW    = 2'd1;
  localparam logic [1:0] RC_ABOVE    = 2'd2;
  localparam logic [1:0] RC_FLAT     = 2'd3;

  // Reset value of the entry count register
  localparam logic [6:0] ENTRIES_RESET = 7'd2;

  // Serial unit step counts: 32 multiplier bits, 33 quotient bits
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 33;

  localparam logic signed [31:0] Y_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Y_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_SETUP,
    S_MUL,
    S_DIV_LOAD,
    S_DIV,
    S_SUM,
    S_OUT
  } state_t;

  // Table read address selection
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_ONE,
    RD_NEXT
  } rdsel_t;

  typedef struct packed {
    logic   in_ready;
    rdsel_t rd_sel;
    logic   prev_load;
    logic   cur_load;
    logic   seg_init;
    logic   seg_inc;
    logic   setup;
    logic   mul_step;
    logic   div_init;
    logic   div_step;
    logic   res_below;
    logic   res_above;
    logic   res_flat;
    logic   res_sum;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_query;
    logic below;
    logic above;
    logic seg_more;
    logic dx_zero;
    logic mul_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/pwlti_channels.sv
// Valid/ready channel interfaces for the interpolator's load/query and result beats.
// Depends on nothing; payload widths follow the block's field list.
`timescale 1ns / 1ps
`default_nettype none

interface pwlti_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [5:0]         entry_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, output action, output entry_index, output x_value,
                  output y_value, input ready);
  modport sink   (input valid, input action, input entry_index, input x_value,
                  input y_value, output ready);
endinterface

interface pwlti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_result;
  logic [1:0]         range_code;

  modport source (output valid, output y_result, output range_code, input ready);
  modport sink   (input valid, input y_result, input range_code, output ready);
endinterface

`default_nettype wire

### hw/rtl/piecewise_linear_table_interp_core.sv
// Top level of the piecewise linear table interpolator.
// Depends on pwlti_pkg, pwlti_channels, pwlti_ctrl and pwlti_datapath.
//
// Usage:
//   in_ch carries one beat per item. action = load writes x_value/y_value
//   into entry entry_index (ignored at or above TABLE_DEPTH) and gives no result.
//   action = query interpolates at x_value and gives one beat on out_ch:
//   y_result (Q16.16, saturated) and range_code.
//   cfg_we/cfg_wdata set entries_used; write it only while the block is idle.
// Course of a query, from acceptance to the result register:
//   below the first x: only entry 0 is read; above the last x: entry 0 and
//   the last entry in use are read; interior: the search reads one entry per
//   cycle from the single read port of the table, then a 32-step shift-add
//   multiply and a 33-step restoring divide run; zero-width segment: the
//   search only, with no multiply or divide. One item is worked on at a time;
//   the next is taken once the result sits in the output register.
// Reset: entries_used returns to 2 and the output register empties. The
//   table memory is not cleared; read only entries that have been loaded.
// Stall: a result held by out_ch.ready low stays put, and a new query may be
//   accepted and computed meanwhile, waiting before its own hand-off.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  pwlti_in_if.sink        in_ch,
  pwlti_out_if.source     out_ch
);

  // Commands downstream, status back up: the only link between the halves
  pwlti_pkg::cmd_t    cmd;
  pwlti_pkg::status_t status;

  pwlti_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // Table memory, search registers and the serial arithmetic
  pwlti_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

### hw/rtl/pwlti_ctrl.sv
// Sequencing state machine of the interpolator: search, multiply, divide, emit.
// Depends on pwlti_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pwlti_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pwlti_pkg::status_t status,
  output pwlti_pkg::cmd_t         cmd
);

  pwlti_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwlti_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwlti_pkg::S_IDLE: begin
        if (status.in_valid && status.in_query) state_nxt = pwlti_pkg::S_FIRST;
      end
      pwlti_pkg::S_FIRST: begin
        state_nxt = status.below ? pwlti_pkg::S_OUT : pwlti_pkg::S_LAST;
      end
      pwlti_pkg::S_LAST: begin
        state_nxt = status.above ? pwlti_pkg::S_OUT : pwlti_pkg::S_SCAN;
      end
      pwlti_pkg::S_SCAN: begin
        if (!(status.above && status.seg_more)) state_nxt = pwlti_pkg::S_SETUP;
      end
      pwlti_pkg::S_SETUP: begin
        state_nxt = status.dx_zero ? pwlti_pkg::S_OUT : pwlti_pkg::S_MUL;
      end
      pwlti_pkg::S_MUL: begin
        if (status.mul_last) state_nxt = pwlti_pkg::S_DIV_LOAD;
      end
      pwlti_pkg::S_DIV_LOAD: begin
        state_nxt = pwlti_pkg::S_DIV;
      end
      pwlti_pkg::S_DIV: begin
        if (status.div_last) state_nxt = pwlti_pkg::S_SUM;
      end
      pwlti_pkg::S_SUM: begin
        state_nxt = pwlti_pkg::S_OUT;
      end
      pwlti_pkg::S_OUT: begin
        if (status.out_free) state_nxt = pwlti_pkg::S_IDLE;
      end
      default: state_nxt = pwlti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = pwlti_pkg::RD_ZERO;
    unique case (state_r)
      pwlti_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      pwlti_pkg::S_FIRST: begin
        cmd.prev_load = 1'b1;
        if (status.below) begin
          cmd.res_below = 1'b1;
        end else begin
          cmd.rd_sel = pwlti_pkg::RD_LAST;
        end
      end
      pwlti_pkg::S_LAST: begin
        if (status.above) begin
          cmd.res_above = 1'b1;
        end else begin
          cmd.rd_sel   = pwlti_pkg::RD_ONE;
          cmd.seg_init = 1'b1;
        end
      end
      pwlti_pkg::S_SCAN: begin
        if (status.above && status.seg_more) begin
          cmd.prev_load = 1'b1;
          cmd.seg_inc   = 1'b1;
          cmd.rd_sel    = pwlti_pkg::RD_NEXT;
        end else begin
          cmd.cur_load = 1'b1;
        end
      end
      pwlti_pkg::S_SETUP: begin
        cmd.setup    = 1'b1;
        cmd.res_flat = status.dx_zero;
      end
      pwlti_pkg::S_MUL:      cmd.mul_step = 1'b1;
      pwlti_pkg::S_DIV_LOAD: cmd.div_init = 1'b1;
      pwlti_pkg::S_DIV:      cmd.div_step = 1'b1;
      pwlti_pkg::S_SUM:      cmd.res_sum  = 1'b1;
      pwlti_pkg::S_OUT:      cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result register loaded while still occupied");

  a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.res_below, cmd.res_above, cmd.res_flat, cmd.res_sum}))
    else $error("more than one result source selected");

  a_query_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_ready && status.in_valid && status.in_query) |=> state_r == pwlti_pkg::S_FIRST)
    else $error("accepted query did not start the table search");

endmodule

`default_nettype wire

### hw/rtl/pwlti_datapath.sv
// Datapath: breakpoint memory, search registers, serial multiplier and divider,
// saturation and result register. Depends on pwlti_pkg and pwlti_channels.
`timescale 1ns / 1ps
`default_nettype none

module pwlti_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata,
  pwlti_in_if.sink                in_ch,
  pwlti_out_if.source             out_ch,
  input  wire pwlti_pkg::cmd_t    cmd,
  output pwlti_pkg::status_t      status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [31:0] x_mem [TABLE_DEPTH];
  logic signed [31:0] y_mem [TABLE_DEPTH];

  logic [6:0]         cfg_used_r;
  logic               out_valid_r;
  logic signed [31:0] out_y_r;
  logic [1:0]         out_code_r;

  logic signed [31:0] rd_x_r, rd_y_r;
  logic signed [31:0] xq_r, x0_r, y0_r, x1_r, y1_r;
  logic [AW-1:0]      seg_r;
  logic [31:0]        dx_r;
  logic [32:0]        mcand_r;
  logic [64:0]        prod_r;
  logic [31:0]        rem_r;
  logic [32:0]        quo_r;
  logic               neg_r;
  logic [5:0]         cnt_r;
  logic signed [31:0] res_y_r;
  logic [1:0]         res_code_r;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr, last_idx;
  logic [31:0]   used_ext;
  logic [32:0]   dx_full, dxq_full, dy_full, mag;
  logic [32:0]   add_term;
  logic [33:0]   mul_sum;
  logic [64:0]   prod_nxt;
  logic [32:0]   div_trial, div_diff;
  logic          div_ge;
  logic [31:0]   rem_nxt;
  logic [32:0]   quo_nxt;
  logic [34:0]   y0_ext, q_ext, sum_full;
  logic signed [31:0] sat_y;

  assign accept      = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  // Clamp the entry count into the range the table supports
  assign used_ext = 32'(cfg_used_r);
  always_comb begin
    if (used_ext < 32'd2) begin
      last_idx = AW'(1);
    end else if (used_ext > 32'(TABLE_DEPTH)) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(used_ext - 32'd1);
    end
  end

  assign wr_en   = accept && (in_ch.action == pwlti_pkg::ACT_LOAD)
                   && (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_ch.entry_index);

  always_comb begin
    case (cmd.rd_sel)
      pwlti_pkg::RD_ZERO: rd_addr = '0;
      pwlti_pkg::RD_LAST: rd_addr = last_idx;
      pwlti_pkg::RD_ONE:  rd_addr = AW'(1);
      pwlti_pkg::RD_NEXT: rd_addr = seg_r + AW'(1);
      default:            rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= in_ch.x_value;
      y_mem[wr_addr] <= in_ch.y_value;
    end
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
  end

  // Segment set-up: offsets are known non-negative from the search
  assign dx_full  = {x1_r[31], x1_r} - {x0_r[31], x0_r};
  assign dxq_full = {xq_r[31], xq_r} - {x0_r[31], x0_r};
  assign dy_full  = {y1_r[31], y1_r} - {y0_r[31], y0_r};
  assign mag      = dy_full[32] ? (33'd0 - dy_full) : dy_full;

  // Shift-add multiply, one multiplier bit per step
  assign add_term = prod_r[0] ? mcand_r : 33'd0;
  assign mul_sum  = {1'b0, prod_r[64:32]} + {1'b0, add_term};
  assign prod_nxt = {mul_sum, prod_r[31:1]};

  // Restoring divide, one quotient bit per step; remainder stays below dx
  assign div_trial = {rem_r, quo_r[32]};
  assign div_diff  = div_trial - {1'b0, dx_r};
  assign div_ge    = div_trial >= {1'b0, dx_r};
  assign rem_nxt   = div_ge ? div_diff[31:0] : div_trial[31:0];
  assign quo_nxt   = {quo_r[31:0], div_ge};

  assign y0_ext   = {{3{y0_r[31]}}, y0_r};
  assign q_ext    = {2'b00, quo_r};
  assign sum_full = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);
  always_comb begin
    if (sum_full[34] && (sum_full[33:31] != 3'b111)) begin
      sat_y = pwlti_pkg::Y_MIN;
    end else if (!sum_full[34] && (sum_full[33:31] != 3'b000)) begin
      sat_y = pwlti_pkg::Y_MAX;
    end else begin
      sat_y = sum_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_used_r  <= pwlti_pkg::ENTRIES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_used_r <= cfg_wdata;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) xq_r <= in_ch.x_value;
    if (cmd.prev_load) begin
      x0_r <= rd_x_r;
      y0_r <= rd_y_r;
    end
    if (cmd.cur_load) begin
      x1_r <= rd_x_r;
      y1_r <= rd_y_r;
    end
    if (cmd.seg_init) begin
      seg_r <= AW'(1);
    end else if (cmd.seg_inc) begin
      seg_r <= seg_r + AW'(1);
    end
    if (cmd.setup) begin
      dx_r    <= dx_full[31:0];
      mcand_r <= mag;
      prod_r  <= {33'd0, dxq_full[31:0]};
      neg_r   <= dy_full[32];
      cnt_r   <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      cnt_r  <= cnt_r + 6'd1;
    end
    if (cmd.div_init) begin
      rem_r <= {1'b0, prod_r[63:33]};
      quo_r <= prod_r[32:0];
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.res_below) begin
      res_y_r    <= rd_y_r;
      res_code_r <= pwlti_pkg::RC_BELOW;
    end
    if (cmd.res_above) begin
      res_y_r    <= rd_y_r;
      res_code_r <= pwlti_pkg::RC_ABOVE;
    end
    if (cmd.res_flat) begin
      res_y_r    <= y1_r;
      res_code_r <= pwlti_pkg::RC_FLAT;
    end
    if (cmd.res_sum) begin
      res_y_r    <= sat_y;
      res_code_r <= pwlti_pkg::RC_INTERIOR;
    end
    if (cmd.out_load) begin
      out_y_r    <= res_y_r;
      out_code_r <= res_code_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.y_result   = out_y_r;
  assign out_ch.range_code = out_code_r;

  assign status.in_valid = in_ch.valid;
  assign status.in_query = in_ch.action == pwlti_pkg::ACT_QUERY;
  assign status.below    = xq_r < rd_x_r;
  assign status.above    = xq_r > rd_x_r;
  assign status.seg_more = seg_r < last_idx;
  assign status.dx_zero  = x1_r == x0_r;
  assign status.mul_last = cnt_r == 6'(pwlti_pkg::MUL_STEPS - 1);
  assign status.div_last = cnt_r == 6'(pwlti_pkg::DIV_STEPS - 1);
  assign status.out_free = !out_valid_r || out_ch.ready;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < dx_r)
    else $error("divider remainder not below divisor");

  a_product_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> !prod_r[64])
    else $error("product overflowed 64 bits");

  a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cur_load |-> seg_r <= last_idx)
    else $error("segment search ran past the last entry");

endmodule

`default_nettype wire

### tb/pwlti_interp_checker.sv
// Scoreboard for the piecewise linear table interpolator: watches both channels
// and the entry-count port, predicts each query's result and compares it.
// Depends on pwlti_pkg and the pwlti_in_if / pwlti_out_if channel interfaces.
`timescale 1ns / 1ps

module pwlti_interp_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  pwlti_in_if             in_mon,
  pwlti_out_if            out_mon,
  output int unsigned     fail_count,
  output int unsigned     pending_count
);

  typedef struct packed {
    logic [31:0] y;
    logic [1:0]  code;
  } interp_result_t;

  logic signed [31:0] x_tab [TABLE_DEPTH];
  logic signed [31:0] y_tab [TABLE_DEPTH];
  logic [6:0]         entries_cfg;
  interp_result_t     awaited_results [$];

  function automatic interp_result_t interpolate_y(logic signed [31:0] xq);
    int                n;
    int                seg;
    longint            x0, x1, y0, y1, dx, dxq, dy, res;
    longint unsigned   mag, quo;
    interp_result_t    r;
    n = int'(entries_cfg);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (xq < x_tab[0]) begin
      r.y = y_tab[0];
      r.code = pwlti_pkg::RC_BELOW;
      return r;
    end
    if (xq > x_tab[n-1]) begin
      r.y = y_tab[n-1];
      r.code = pwlti_pkg::RC_ABOVE;
      return r;
    end
    seg = 1;
    while (seg < n - 1 && xq > x_tab[seg]) seg++;
    x0 = longint'(x_tab[seg-1]);
    x1 = longint'(x_tab[seg]);
    y0 = longint'(y_tab[seg-1]);
    y1 = longint'(y_tab[seg]);
    dx = x1 - x0;
    if (dx == 0) begin
      r.y = y_tab[seg];
      r.code = pwlti_pkg::RC_FLAT;
      return r;
    end
    dxq = longint'(xq) - x0;
    dy  = y1 - y0;
    mag = (dy < 0) ? longint'(-dy) : dy;
    quo = (mag * longint'(dxq)) / longint'(dx);
    res = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
    if (res > longint'(pwlti_pkg::Y_MAX)) res = longint'(pwlti_pkg::Y_MAX);
    if (res < longint'(pwlti_pkg::Y_MIN)) res = longint'(pwlti_pkg::Y_MIN);
    r.y = res[31:0];
    r.code = pwlti_pkg::RC_INTERIOR;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    interp_result_t exp_r;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      entries_cfg = pwlti_pkg::ENTRIES_RESET;
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      // drain first: a result beat never belongs to a query taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result beat: y_result %08h range_code %0d",
                 out_mon.y_result, out_mon.range_code);
          errs++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_mon.y_result !== exp_r.y) begin
            $error("y_result: expected %08h, actual %08h", exp_r.y, out_mon.y_result);
            errs++;
          end
          if (out_mon.range_code !== exp_r.code) begin
            $error("range_code: expected %0d, actual %0d", exp_r.code, out_mon.range_code);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == pwlti_pkg::ACT_LOAD) begin
          if (int'(in_mon.entry_index) < TABLE_DEPTH) begin
            x_tab[in_mon.entry_index] = in_mon.x_value;
            y_tab[in_mon.entry_index] = in_mon.y_value;
          end
        end else begin
          awaited_results = {awaited_results, interpolate_y(in_mon.x_value)};
        end
      end
      if (cfg_we) entries_cfg = cfg_wdata;
      fail_count <= fail_count + errs;
    end
    pending_count <= awaited_results.size();
  end

endmodule

### tb/tb_piecewise_linear_table_interp_core.sv
// Testbench top for the piecewise linear table interpolator: drives table loads,
// queries and entry-count writes, and gives the verdict.
// Depends on pwlti_pkg, the channel interfaces, the core and pwlti_interp_checker.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp_core;

  localparam int TABLE_DEPTH     = 64;
  localparam int ITEM_TARGET     = 1350;
  // allow well over the longest query before a cfg write
  localparam int SETTLE_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam longint X_LOWEST    = -64'sd2147483648;
  localparam longint X_HIGHEST   = 64'sd2147483647;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  int unsigned fail_count;
  int unsigned pending_count;

  pwlti_in_if  in_ch ();
  pwlti_out_if out_ch ();

  piecewise_linear_table_interp_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pwlti_interp_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Shadow of the breakpoint x values, used only to aim queries at segments
  longint tbl_x [TABLE_DEPTH];
  int     items_sent   = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall the result channel per cycle at the current rate
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Count cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_piecewise_linear_table_interp_core: done, errors");
    $finish;
  end

  // Uniform pick over [lo, hi]; spans up to the full 32-bit range
  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span, r;
    span = longint'(hi - lo) + 1;
    r = {$urandom(), $urandom()};
    return lo + longint'(r % span);
  endfunction

  // Breakpoint y: mostly full range, sometimes a small value around zero
  function automatic logic [31:0] rand_y();
    if ($urandom_range(3) == 0)
      return 32'(int'($urandom_range(65535)) - 32768);
    return $urandom();
  endfunction

  // Aim a query: exact breakpoints, inside a segment, below, above, or anywhere
  function automatic logic [31:0] pick_query_x(int count);
    int     c, k;
    longint a, b, x;
    c = $urandom_range(99);
    k = $urandom_range(count - 2);
    a = tbl_x[k];
    b = tbl_x[k+1];
    if (c < 20)
      x = tbl_x[$urandom_range(count - 1)];
    else if (c < 65)
      x = (a <= b) ? rand_between(a, b) : rand_between(b, a);
    else if (c < 75 && tbl_x[0] > X_LOWEST)
      x = rand_between(X_LOWEST, tbl_x[0] - 1);
    else if (c < 85 && tbl_x[count-1] < X_HIGHEST)
      x = rand_between(tbl_x[count-1] + 1, X_HIGHEST);
    else
      x = longint'(int'($urandom()));
    return x[31:0];
  endfunction

  // Drive one beat: idle first at the sender rate, then hold until taken.
  // Valid stays high between back-to-back beats.
  task automatic send_beat(logic act, logic [5:0] idx, logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= idx;
    in_ch.x_value     <= x;
    in_ch.y_value     <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_query(logic [31:0] x);
    send_beat(pwlti_pkg::ACT_QUERY, 6'($urandom()), x, $urandom());
  endtask

  // Drop valid, wait for every awaited result, then let any trailing load finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries_used(logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 88;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 88;
      end
      default: begin
        send_idle_pct  = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // Load entries 0..count-1: mostly rising x with some repeats (flat segments),
  // sometimes scrambled x so the table does not rise
  task automatic fill_table(int count);
    longint step_max, acc;
    int     i;
    if ($urandom_range(99) < 15) begin
      for (i = 0; i < count; i++) tbl_x[i] = longint'(int'($urandom()));
    end else begin
      case ($urandom_range(2))
        0:       step_max = 16;
        1:       step_max = 64'sd131072;
        default: step_max = 64'sd4294967295 / (count - 1);
      endcase
      acc = rand_between(X_LOWEST, X_HIGHEST - (count - 1) * step_max);
      for (i = 0; i < count; i++) begin
        tbl_x[i] = acc;
        acc += ($urandom_range(9) == 0) ? 0 : rand_between(1, step_max);
      end
    end
    for (i = 0; i < count; i++)
      send_beat(pwlti_pkg::ACT_LOAD, 6'(i), tbl_x[i][31:0], rand_y());
  endtask

  initial begin : stimulus
    int         phase;
    int         pick;
    int         neff;
    int         idx;
    logic [6:0] cfg_val;
    // hold every input at a known value from time zero
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = pwlti_pkg::ACT_LOAD;
    in_ch.entry_index = '0;
    in_ch.x_value     = '0;
    in_ch.y_value     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset entry count of two, segment from -100.0 to +100.0
    set_idling(0);
    send_beat(pwlti_pkg::ACT_LOAD, 6'd0, 32'hFF9C_0000, 32'h7FFF_FFFF);
    send_beat(pwlti_pkg::ACT_LOAD, 6'd1, 32'h0064_0000, 32'h8000_0000);
    // top index, outside the entries in use
    send_beat(pwlti_pkg::ACT_LOAD, 6'd63, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_query(32'h8000_0000);          // below the first x
    send_query(32'h7FFF_FFFF);          // above the last x
    send_query(32'h0000_0000);          // midpoint
    send_query(32'hFF9C_0000);          // exactly on the first breakpoint
    send_query(32'h0064_0000);          // exactly on the last breakpoint
    // collapse the segment to zero width
    send_beat(pwlti_pkg::ACT_LOAD, 6'd1, 32'hFF9C_0000, 32'h1234_5678);
    send_query(32'hFF9C_0000);          // flat segment: upper y, no divide
    send_query(32'hFF9C_0001);          // just past the collapsed table
    wait_drained();

    // Directed: three entries spanning the whole x range, y swinging end to end
    write_entries_used(7'd3);
    send_beat(pwlti_pkg::ACT_LOAD, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(pwlti_pkg::ACT_LOAD, 6'd1, 32'h0000_0000, 32'h8000_0000);
    send_beat(pwlti_pkg::ACT_LOAD, 6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);
    send_query(32'h0000_0000);
    send_query(32'h0000_0001);
    send_query(32'h7FFF_FFFF);
    wait_drained();

    // Random phases: each sets the entry count while idle, loads the table,
    // then mixes queries with stray loads. Cycle through the idling modes.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      case (phase)
        0:       cfg_val = 7'd64;
        1:       cfg_val = 7'd2;
        2:       cfg_val = 7'd127;
        3:       cfg_val = 7'($urandom_range(1));
        default: begin
          if (pick < 5)       cfg_val = 7'd64;
          else if (pick < 7)  cfg_val = 7'($urandom_range(1));
          else if (pick < 9)  cfg_val = 7'($urandom_range(65, 127));
          else if (pick < 15) cfg_val = 7'($urandom_range(11, 63));
          else                cfg_val = 7'($urandom_range(2, 10));
        end
      endcase
      neff = (cfg_val < 2) ? 2 : (cfg_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_val);
      set_idling(phase % 4);
      write_entries_used(cfg_val);
      fill_table(neff);
      repeat ($urandom_range(20, 40)) begin
        if ($urandom_range(9) == 0) begin
          // stray load: keep x of an entry in use so the table shape holds
          idx = $urandom_range(TABLE_DEPTH - 1);
          if (idx < neff)
            send_beat(pwlti_pkg::ACT_LOAD, 6'(idx), tbl_x[idx][31:0], rand_y());
          else
            send_beat(pwlti_pkg::ACT_LOAD, 6'(idx), $urandom(), $urandom());
        end else begin
          send_query(pick_query_x(neff));
        end
      end
      wait_drained();
      phase++;
    end

    if (fail_count == 0 && pending_count == 0)
      $display("tb_piecewise_linear_table_interp_core: done, clean");
    else
      $display("tb_piecewise_linear_table_interp_core: done, errors");
    $finish;
  end

endmodule
